// ----- src/byte_ring_buffer_rewind_top_assert.svh -----
// ----------------------------------------------------------------------------
// byte ring buffer assertion macros
// clocked assertion shorthands shared by the checker
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_REWIND_TOP_ASSERT_SVH
`define BYTE_RING_BUFFER_REWIND_TOP_ASSERT_SVH

// plain property, checked on every edge outside reset
`define BRRW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication shorthand
`define BRRW_ASSERT_IMPLY(label, ante, cons, msg) \
	`BRRW_ASSERT(label, (ante) |-> (cons), msg)

// next-cycle implication shorthand
`define BRRW_ASSERT_NEXT(label, ante, cons, msg) \
	`BRRW_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ----- src/brrw_pkg.sv -----
// ----------------------------------------------------------------------------
// brrw_pkg
// shared constants, codes and controller/datapath signal groups
// ----------------------------------------------------------------------------
`default_nettype none

package brrw_pkg;

	localparam int unsigned DEPTH    = 1024;
	localparam int unsigned MAX_READ = 16;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CNT_W  = 11;
	localparam int unsigned CMD_W  = 2;
	localparam int unsigned STS_W  = 2;
	localparam int unsigned PTR_W  = $clog2(DEPTH);
	localparam int unsigned LVL_W  = $clog2(DEPTH + 1);
	localparam int unsigned RLEN_W = $clog2(MAX_READ + 1);
	localparam int unsigned SUM_W  = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;

	localparam int unsigned IN_DATA_W  = ((BYTE_W + CNT_W + 7) / 8) * 8;
	localparam int unsigned OUT_DATA_W = ((BYTE_W + LVL_W + 7) / 8) * 8;
	localparam int unsigned OUT_PAD_W  = OUT_DATA_W - BYTE_W - LVL_W;
	localparam int unsigned OUT_USER_W = 1 + STS_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE  = 2'd0,
		CMD_READ   = 2'd1,
		CMD_SKIP   = 2'd2,
		CMD_REWIND = 2'd3
	} cmd_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK       = 2'd0,
		STS_OVERFLOW = 2'd1,
		STS_RANGE    = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_READ = 1'b1
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic exec_single;  // run a one-result command
		logic start_read;   // start a read burst, first ram read
		logic next_byte;    // move ram data to output, next ram read if any
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;       // output register can take a beat this cycle
		logic rem_zero;       // no more bytes to fetch in this burst
		logic read_nonempty;  // incoming read takes at least one byte
	} sts_t;

endpackage

`default_nettype wire

// ----- src/brrw_ram.sv -----
// ----------------------------------------------------------------------------
// brrw_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module brrw_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- src/brrw_ctrl.sv -----
// ----------------------------------------------------------------------------
// brrw_ctrl
// command sequencer: single-beat commands and read bursts
// ----------------------------------------------------------------------------
`default_nettype none

module brrw_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire brrw_pkg::cmd_t command,
	input  wire brrw_pkg::sts_t sts,
	output logic               in_ready,
	output brrw_pkg::ctl_t     ctl
);

	brrw_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= brrw_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		in_ready        = 1'b0;
		ctl.exec_single = 1'b0;
		ctl.start_read  = 1'b0;
		ctl.next_byte   = 1'b0;
		case (state_q)
			brrw_pkg::S_IDLE: begin
				in_ready = sts.out_free;
				if (in_valid && sts.out_free) begin
					if (command == brrw_pkg::CMD_READ && sts.read_nonempty) begin
						ctl.start_read = 1'b1;
						state_d        = brrw_pkg::S_READ;
					end else begin
						ctl.exec_single = 1'b1;
					end
				end
			end
			brrw_pkg::S_READ: begin
				// one byte per cycle while the output side keeps up
				if (sts.out_free) begin
					ctl.next_byte = 1'b1;
					if (sts.rem_zero) begin
						state_d = brrw_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_d = brrw_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- src/brrw_dp.sv -----
// ----------------------------------------------------------------------------
// brrw_dp
// ring store, pointers, fill level and the output register
// ----------------------------------------------------------------------------
`default_nettype none

module brrw_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire brrw_pkg::ctl_t                ctl,
	input  wire brrw_pkg::cmd_t                command,
	input  wire logic [brrw_pkg::BYTE_W-1:0]   in_byte,
	input  wire logic [brrw_pkg::CNT_W-1:0]    count,
	input  wire logic                          out_ready,
	output brrw_pkg::sts_t                     sts,
	output logic                               out_valid,
	output logic      [brrw_pkg::BYTE_W-1:0]   out_byte,
	output logic                               byte_valid,
	output logic                               last,
	output logic      [brrw_pkg::STS_W-1:0]    status,
	output logic      [brrw_pkg::LVL_W-1:0]    level
);

	localparam int unsigned PtrW  = brrw_pkg::PTR_W;
	localparam int unsigned LvlW  = brrw_pkg::LVL_W;
	localparam int unsigned RlenW = brrw_pkg::RLEN_W;
	localparam int unsigned SumW  = brrw_pkg::SUM_W;

	logic [PtrW-1:0]  rd_ptr_q, wr_ptr_q;
	logic [LvlW-1:0]  fill_q;
	logic [RlenW-1:0] rem_q;
	logic             out_valid_q;
	logic [brrw_pkg::BYTE_W-1:0] out_byte_q;
	logic             out_bv_q, out_last_q;
	logic [brrw_pkg::STS_W-1:0]  out_status_q;
	logic [LvlW-1:0]  out_level_q;

	logic [RlenW-1:0] n_clamp, n_take;
	logic [PtrW-1:0]  rd_inc, wr_inc, skip_ptr, rew_ptr;
	logic [SumW-1:0]  skip_sum, rew_diff;
	logic [LvlW-1:0]  free_space;
	logic             full, skip_ok, rew_ok;
	logic             ram_we, ram_re, fetch_more;
	logic [brrw_pkg::BYTE_W-1:0] ram_rdata;

	// next state of a one-result command
	logic [PtrW-1:0]           sgl_rd_ptr, sgl_wr_ptr;
	logic [LvlW-1:0]           sgl_fill;
	brrw_pkg::status_t         sgl_status;

	// read length: min(count, max read, fill)
	assign n_clamp = (count > brrw_pkg::CNT_W'(brrw_pkg::MAX_READ)) ?
	                 RlenW'(brrw_pkg::MAX_READ) : count[RlenW-1:0];
	assign n_take  = (LvlW'(n_clamp) > fill_q) ? fill_q[RlenW-1:0] : n_clamp;

	assign rd_inc = (rd_ptr_q == PtrW'(brrw_pkg::DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
	assign wr_inc = (wr_ptr_q == PtrW'(brrw_pkg::DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;

	assign full       = (fill_q == LvlW'(brrw_pkg::DEPTH));
	assign free_space = LvlW'(brrw_pkg::DEPTH) - fill_q;
	assign skip_ok    = (SumW'(count) <= SumW'(fill_q));
	assign rew_ok     = (SumW'(count) <= SumW'(free_space));

	// skip stays under two laps, so one conditional subtract wraps it
	assign skip_sum = SumW'(rd_ptr_q) + SumW'(count);
	assign skip_ptr = (skip_sum >= SumW'(brrw_pkg::DEPTH)) ?
	                  PtrW'(skip_sum - SumW'(brrw_pkg::DEPTH)) : PtrW'(skip_sum);
	assign rew_diff = SumW'(rd_ptr_q) - SumW'(count);
	assign rew_ptr  = (SumW'(count) > SumW'(rd_ptr_q)) ?
	                  PtrW'(rew_diff + SumW'(brrw_pkg::DEPTH)) : PtrW'(rew_diff);

	always_comb begin
		sgl_rd_ptr = rd_ptr_q;
		sgl_wr_ptr = wr_ptr_q;
		sgl_fill   = fill_q;
		sgl_status = brrw_pkg::STS_OK;
		case (command)
			brrw_pkg::CMD_WRITE: begin
				if (full) begin
					sgl_status = brrw_pkg::STS_OVERFLOW;
				end else begin
					sgl_wr_ptr = wr_inc;
					sgl_fill   = fill_q + 1'b1;
				end
			end
			brrw_pkg::CMD_SKIP: begin
				if (skip_ok) begin
					sgl_rd_ptr = skip_ptr;
					sgl_fill   = fill_q - LvlW'(count);
				end else begin
					sgl_status = brrw_pkg::STS_RANGE;
				end
			end
			brrw_pkg::CMD_REWIND: begin
				if (rew_ok) begin
					sgl_rd_ptr = rew_ptr;
					sgl_fill   = fill_q + LvlW'(count);
				end else begin
					sgl_status = brrw_pkg::STS_RANGE;
				end
			end
			default: begin
				// empty read: nothing moves
			end
		endcase
	end

	assign fetch_more = ctl.next_byte && (rem_q != '0);
	assign ram_we     = ctl.exec_single && (command == brrw_pkg::CMD_WRITE) && !full;
	assign ram_re     = ctl.start_read || fetch_more;

	brrw_ram #(
		.Width (brrw_pkg::BYTE_W),
		.Depth (brrw_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_ptr_q),
		.wdata (in_byte),
		.re    (ram_re),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			fill_q      <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.exec_single) begin
				rd_ptr_q <= sgl_rd_ptr;
				wr_ptr_q <= sgl_wr_ptr;
				fill_q   <= sgl_fill;
			end else if (ctl.start_read) begin
				rd_ptr_q <= rd_inc;
				fill_q   <= fill_q - 1'b1;
				rem_q    <= n_take - 1'b1;
			end else if (fetch_more) begin
				rd_ptr_q <= rd_inc;
				fill_q   <= fill_q - 1'b1;
				rem_q    <= rem_q - 1'b1;
			end
			if (ctl.exec_single || ctl.next_byte) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload, fill_q already counts every byte fetched so far
	always_ff @(posedge clk) begin
		if (ctl.exec_single) begin
			out_byte_q   <= '0;
			out_bv_q     <= 1'b0;
			out_last_q   <= 1'b1;
			out_status_q <= sgl_status;
			out_level_q  <= sgl_fill;
		end else if (ctl.next_byte) begin
			out_byte_q   <= ram_rdata;
			out_bv_q     <= 1'b1;
			out_last_q   <= (rem_q == '0);
			out_status_q <= brrw_pkg::STS_OK;
			out_level_q  <= fill_q;
		end
	end

	assign sts.out_free      = !out_valid_q || out_ready;
	assign sts.rem_zero      = (rem_q == '0);
	assign sts.read_nonempty = (n_take != '0);

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = out_bv_q;
	assign last       = out_last_q;
	assign status     = out_status_q;
	assign level      = out_level_q;

endmodule

`default_nettype wire

// ----- src/byte_ring_buffer_rewind_top.sv -----
// ----------------------------------------------------------------------------
// byte_ring_buffer_rewind_top
// circular byte store with write, burst read, skip and rewind commands
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake                    payload
//  s_axis   in   s_axis_tvalid/s_axis_tready  tuser: command; tdata: in_byte, count
//  m_axis   out  m_axis_tvalid/m_axis_tready  tdata: out_byte, level; tlast: last;
//                                             tuser: byte_valid, status
//
//  write, skip, rewind and an empty read: a single beat, result registered in the cycle after the beat
//  a read of n bytes: one byte per cycle while m_axis keeps up, behind the registered read
//    port of the ring store; no new command is taken until the last byte is out
//  the output register lets a new beat in while the previous result is being taken
//  a stall on m_axis holds the burst in place, nothing is dropped or repeated
//  arst_n clears pointers, fill level and state; the store needs no clearing pass
//
`default_nettype none

module byte_ring_buffer_rewind_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// slave side
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  wire logic [brrw_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // in_byte, count, zero pad
	input  wire logic [brrw_pkg::CMD_W-1:0]         s_axis_tuser,  // command
	// master side
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	output logic      [brrw_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // out_byte, level, zero pad
	output logic      [brrw_pkg::OUT_USER_W-1:0]    m_axis_tuser,  // byte_valid, status
	output logic                                    m_axis_tlast   // last
);

	brrw_pkg::ctl_t  ctl;
	brrw_pkg::sts_t  sts;
	brrw_pkg::cmd_t  command;

	logic [brrw_pkg::BYTE_W-1:0] in_byte;
	logic [brrw_pkg::CNT_W-1:0]  count;
	logic [brrw_pkg::BYTE_W-1:0] out_byte;
	logic                        byte_valid;
	logic [brrw_pkg::STS_W-1:0]  status;
	logic [brrw_pkg::LVL_W-1:0]  level;

	// unpack the incoming beat
	assign command = brrw_pkg::cmd_t'(s_axis_tuser);
	assign in_byte = s_axis_tdata[brrw_pkg::BYTE_W-1:0];
	assign count   = s_axis_tdata[brrw_pkg::BYTE_W +: brrw_pkg::CNT_W];

	// sequencer: idle takes commands, read state streams the burst
	brrw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.command  (command),
		.sts      (sts),
		.in_ready (s_axis_tready),
		.ctl      (ctl)
	);

	// ring store, pointers, level and output register
	brrw_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.command    (command),
		.in_byte    (in_byte),
		.count      (count),
		.out_ready  (m_axis_tready),
		.sts        (sts),
		.out_valid  (m_axis_tvalid),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.last       (m_axis_tlast),
		.status     (status),
		.level      (level)
	);

	// pack the outgoing beat
	assign m_axis_tdata = {{brrw_pkg::OUT_PAD_W{1'b0}}, level, out_byte};
	assign m_axis_tuser = {status, byte_valid};

endmodule

`default_nettype wire

// ----- src/brrw_chk.sv -----
// ----------------------------------------------------------------------------
// brrw_chk
// port-level checks for the byte ring buffer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "byte_ring_buffer_rewind_top_assert.svh"

module brrw_chk (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               s_axis_tready,
	input wire logic                               m_axis_tvalid,
	input wire logic                               m_axis_tready,
	input wire logic [brrw_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	input wire logic [brrw_pkg::OUT_USER_W-1:0]    m_axis_tuser,
	input wire logic                               m_axis_tlast
);

	logic                        m_bv;
	logic [brrw_pkg::STS_W-1:0]  m_status;
	logic [brrw_pkg::LVL_W-1:0]  m_level;
	logic [brrw_pkg::BYTE_W-1:0] m_byte;

	assign m_bv     = m_axis_tuser[0];
	assign m_status = m_axis_tuser[1 +: brrw_pkg::STS_W];
	assign m_level  = m_axis_tdata[brrw_pkg::BYTE_W +: brrw_pkg::LVL_W];
	assign m_byte   = m_axis_tdata[brrw_pkg::BYTE_W-1:0];

	// a stalled beat holds its payload
	`BRRW_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output beat changed under stall")

	// a result without a byte is always the only one of its command
	`BRRW_ASSERT_IMPLY(a_nobyte_last, m_axis_tvalid && !m_bv, m_axis_tlast, "byteless result not marked last")

	// refused commands carry no byte
	`BRRW_ASSERT_IMPLY(a_refused_empty, m_axis_tvalid && (m_status != '0), !m_bv && (m_byte == '0), "refused result carries a byte")

	// while a burst byte other than the last is on the output, no command is taken
	`BRRW_ASSERT_IMPLY(a_burst_busy, m_axis_tvalid && m_bv && !m_axis_tlast, !s_axis_tready, "command taken during a read burst")

	// level never exceeds the store size
	`BRRW_ASSERT_IMPLY(a_level_range, m_axis_tvalid, m_level <= brrw_pkg::LVL_W'(brrw_pkg::DEPTH), "level beyond store size")

endmodule

bind byte_ring_buffer_rewind_top brrw_chk u_brrw_chk (.*);

`default_nettype wire
